// ===== rtl/core/srta_pkg.sv =====
// shared types, constants and the digit-to-ascii function of the radix text converter
`timescale 1ns / 1ps

package srta_pkg;

   localparam int DIGIT_BITS = 6;
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;
   localparam int VALUE_PORT_BITS = 63;

   localparam logic [RADIX_BITS-1:0] MIN_RADIX = 6'd2;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_NULL    = 7'h00;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;

   // control shared by every cell of the digit chain
   typedef struct packed {
      logic                  clear;
      logic                  shift;
      logic [RADIX_BITS-1:0] radix;
   } cell_ctl_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                       input logic upper);
      logic [CHAR_BITS-1:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < DIGIT_TEN) begin
         digit_char = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         digit_char = base + CHAR_BITS'(d - DIGIT_TEN);
      end
   endfunction

endpackage

// ===== rtl/core/signed_radix_to_ascii_top.sv =====
// top level of the signed integer to ascii text converter, bases two to thirty-six
`timescale 1ns / 1ps
// flow: after accept the magnitude bits run bit-serially through the digit cells in ST_CONV,
//   then a sign for a negative value, then the leading zero cells are skipped, then one character
//   per cycle while the receiver is ready; digits are read out of the top cell, all VALUE_BITS cells,
//   and a new item is taken only once the last character is loaded (req_tready only in ST_IDLE)
// a bad radix gives its single flagged item from ST_BAD through the output register
// reset: synchronous, active high, clears control and the output valid; digits are not reset

module signed_radix_to_ascii_top
   import srta_pkg::*;
#(
   parameter int VALUE_BITS = 63,
   parameter int MAX_RADIX  = 36
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: value [62:0], radix [68:63], zero fill [71:69]
   input  logic [71:0] req_tdata,
   // req_tuser: upper_case [0]
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: character [6:0], zero fill [7]
   output logic [7:0]  rsp_tdata,
   // rsp_tuser: bad_radix [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   localparam int NUM_CELLS = VALUE_BITS;
   localparam int CNT_BITS  = $clog2(2 * VALUE_BITS);
   localparam int REM_BITS  = $clog2(NUM_CELLS + 1);
   localparam logic [CNT_BITS-1:0] FEED_END = CNT_BITS'(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] CONV_END = CNT_BITS'(2 * VALUE_BITS - 2);
   localparam logic [REM_BITS-1:0] REM_FULL = REM_BITS'(NUM_CELLS);
   localparam logic [REM_BITS-1:0] REM_ONE  = REM_BITS'(1);
   localparam logic [RADIX_BITS-1:0] MAX_RADIX_CODE = RADIX_BITS'(MAX_RADIX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAD,
      ST_CONV,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type               state_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [VALUE_BITS-1:0]   mag_ff;
   logic [RADIX_BITS-1:0]   radix_ff;
   logic                    upper_ff;
   logic                    neg_ff;
   logic                    lead_ff;
   logic [REM_BITS-1:0]     rem_ff;
   logic                    rsp_valid_ff;
   logic [CHAR_BITS-1:0]    rsp_char_ff;
   logic                    rsp_last_ff;
   logic                    rsp_bad_ff;

   // input unpacking
   logic [VALUE_PORT_BITS-1:0] in_value;
   logic [RADIX_BITS-1:0]      in_radix;
   logic [VALUE_BITS-1:0]      in_v;
   logic                       in_neg;
   logic [VALUE_BITS-1:0]      in_mag;
   logic                       in_bad;
   logic                       accept;

   assign in_value = req_tdata[VALUE_PORT_BITS-1:0];
   assign in_radix = req_tdata[VALUE_PORT_BITS +: RADIX_BITS];
   assign in_v     = in_value[VALUE_BITS-1:0];
   assign in_neg   = in_v[VALUE_BITS-1];
   // the most negative value has magnitude 2^(VALUE_BITS-1), which still fits unsigned
   assign in_mag   = in_neg ? VALUE_BITS'(~in_v + VALUE_BITS'(1)) : in_v;
   assign in_bad   = (in_radix < MIN_RADIX) || (in_radix > MAX_RADIX_CODE);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // output slot is free when empty or being taken this cycle
   logic slot_free;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // chain control
   cell_ctl_type          chain_ctl;
   logic                  feed_active;
   logic [DIGIT_BITS-1:0] top_digit;
   logic                  chain_spill;
   logic                  skip_zero;
   logic                  emit_digit;
   logic                  rsp_load;

   assign feed_active = (state_ff == ST_CONV) && (cnt_ff < FEED_END);
   // leading zeros leave the top without a character, but the last cell always prints
   assign skip_zero   = lead_ff && (top_digit == '0) && (rem_ff > REM_ONE);
   assign emit_digit  = (state_ff == ST_DIGITS) && !skip_zero && slot_free;
   // a new item enters the output register this cycle
   assign rsp_load    = (((state_ff == ST_BAD) || (state_ff == ST_SIGN)) && slot_free)
                        || emit_digit;

   always_comb begin
      chain_ctl.clear = accept && !in_bad;
      chain_ctl.shift = (state_ff == ST_DIGITS) && (skip_zero || slot_free);
      chain_ctl.radix = radix_ff;
   end

   srta_chain #(
      .NUM_CELLS (NUM_CELLS)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctl         (chain_ctl),
      .feed_active (feed_active),
      .feed_bit    (mag_ff[VALUE_BITS-1]),
      .top_digit   (top_digit),
      .spill       (chain_spill)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         lead_ff      <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  radix_ff <= in_radix;
                  upper_ff <= req_tuser;
                  neg_ff   <= in_neg;
                  mag_ff   <= in_mag;
                  cnt_ff   <= '0;
                  state_ff <= in_bad ? ST_BAD : ST_CONV;
               end
            end
            ST_BAD: begin
               if (slot_free) begin
                  rsp_char_ff  <= CHAR_NULL;
                  rsp_last_ff  <= 1'b1;
                  rsp_bad_ff   <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_CONV: begin
               // magnitude bits enter cell zero msb first, the wave then climbs the row
               cnt_ff <= cnt_ff + CNT_BITS'(1);
               if (feed_active) begin
                  mag_ff <= {mag_ff[VALUE_BITS-2:0], 1'b0};
               end
               if (cnt_ff == CONV_END) begin
                  rem_ff   <= REM_FULL;
                  lead_ff  <= 1'b1;
                  state_ff <= neg_ff ? ST_SIGN : ST_DIGITS;
               end
            end
            ST_SIGN: begin
               if (slot_free) begin
                  rsp_char_ff  <= CHAR_MINUS;
                  rsp_last_ff  <= 1'b0;
                  rsp_bad_ff   <= 1'b0;
                  state_ff     <= ST_DIGITS;
               end
            end
            ST_DIGITS: begin
               if (chain_ctl.shift) begin
                  rem_ff <= rem_ff - REM_ONE;
               end
               if (emit_digit) begin
                  rsp_char_ff  <= digit_char(top_digit, upper_ff);
                  rsp_last_ff  <= (rem_ff == REM_ONE);
                  rsp_bad_ff   <= 1'b0;
                  lead_ff      <= 1'b0;
                  if (rem_ff == REM_ONE) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // checks

   // the magnitude always fits the row of cells, no carry leaves the top
   a_no_spill: assert property (@(posedge clock) disable iff (reset) !chain_spill)
      else $error("carry left the top digit cell");

   // every digit read out of the chain is a proper digit of the base
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) |-> (top_digit < radix_ff))
      else $error("digit at top of chain not below radix");

   // a flagged item is a lone null character that closes its text
   a_bad_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata == 8'h00)))
      else $error("bad radix item not a lone null character");

   // no input is taken while a conversion is under way
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |=> ((state_ff == ST_CONV) || !$past(accept)))
      else $error("input accepted during conversion");

endmodule

// ===== rtl/core/srta_cell.sv =====
// one digit cell: clears, doubles its digit plus carry modulo radix, or shifts toward the top
`timescale 1ns / 1ps

module srta_cell
   import srta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic                  active_in,
   input  logic                  carry_in,
   input  logic [DIGIT_BITS-1:0] shift_in,
   output logic [DIGIT_BITS-1:0] digit_out,
   output logic                  active_out,
   output logic                  carry_out
);

   logic [DIGIT_BITS-1:0] digit_ff, digit_in;
   logic                  active_ff, carry_ff, carry_in_nx;
   logic [DIGIT_BITS:0]   sum;
   logic [DIGIT_BITS:0]   diff;
   logic                  wrap;

   // digit stays below radix, so 2*d+c is below twice the radix
   assign sum  = {digit_ff, carry_in};
   assign diff = sum - {1'b0, ctl.radix};
   assign wrap = sum >= {1'b0, ctl.radix};

   always_comb begin
      carry_in_nx = active_in & wrap;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (active_in) begin
         digit_in = wrap ? diff[DIGIT_BITS-1:0] : sum[DIGIT_BITS-1:0];
      end else if (ctl.shift) begin
         digit_in = shift_in;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      if (reset) begin
         active_ff <= 1'b0;
         carry_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         carry_ff  <= carry_in_nx;
      end
   end

   assign digit_out  = digit_ff;
   assign active_out = active_ff;
   assign carry_out  = carry_ff;

endmodule

// ===== rtl/core/srta_chain.sv =====
// row of digit cells, least significant at cell zero, read out from the top cell
`timescale 1ns / 1ps

module srta_chain
   import srta_pkg::*;
#(
   parameter int NUM_CELLS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic                  feed_active,
   input  logic                  feed_bit,
   output logic [DIGIT_BITS-1:0] top_digit,
   output logic                  spill
);

   logic [NUM_CELLS:0]    act_w;
   logic [NUM_CELLS:0]    carry_w;
   logic [DIGIT_BITS-1:0] digit_w [0:NUM_CELLS-1];

   assign act_w[0]   = feed_active;
   assign carry_w[0] = feed_bit;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic [DIGIT_BITS-1:0] below;
      if (i == 0) begin : g_first
         assign below = '0;
      end else begin : g_rest
         assign below = digit_w[i-1];
      end
      srta_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .active_in  (act_w[i]),
         .carry_in   (carry_w[i]),
         .shift_in   (below),
         .digit_out  (digit_w[i]),
         .active_out (act_w[i+1]),
         .carry_out  (carry_w[i+1])
      );
   end

   assign top_digit = digit_w[NUM_CELLS-1];
   // a carry out of the top cell only while the wave is there would mean lost digits
   assign spill     = carry_w[NUM_CELLS] & act_w[NUM_CELLS];

endmodule

// ===== test/signed_radix_to_ascii_top_test.sv =====
// self-checking testbench for the signed integer to ascii text converter
`timescale 1ns / 1ps

module signed_radix_to_ascii_top_test;
   import srta_pkg::*;

   // block configuration and run limits
   localparam int VALUE_BITS = 63;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
   localparam int TEXT_DEPTH = 64;
   // drain after the last result: about one full conversion wave
   localparam int DRAIN_CYCLES = 3 * VALUE_BITS + 64;
   // long receiver hold-off, several conversions long
   localparam int LONG_HOLD_CYCLES = 600;
   // slowest run is ~280 items; the limit covers it several times over
   localparam int CYCLE_LIMIT = 800000;

   // one expected character of the text
   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic                 last;
      logic                 bad;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset;
   logic [71:0] req_tdata;
   logic        req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;

   text_char_type expected_chars[$];

   // run bookkeeping
   int  error_count    = 0;
   int  items_sent     = 0;
   int  chars_checked  = 0;
   int  bad_radix_seen = 0;
   int  cycle_count    = 0;
   bit  idle_enable    = 1'b1;
   int  hold_request   = 0;

   signed_radix_to_ascii_top #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_RADIX (36)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // print one mismatch line and count it
   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // expected text of one value: optional sign, then digits most significant first
   function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                        input logic [RADIX_BITS-1:0] radix,
                                        input logic upper);
      logic [VALUE_BITS-1:0] magnitude;
      logic [DIGIT_BITS-1:0] digits [TEXT_DEPTH];
      logic [DIGIT_BITS-1:0] d;
      logic                  negative;
      int                    count;
      text_char_type         c;
      // out-of-range base: one flagged null character
      if (radix < MIN_RADIX || radix > RADIX_MAX) begin
         c.code = CHAR_NULL;
         c.last = 1'b1;
         c.bad  = 1'b1;
         expected_chars.push_back(c);
         return;
      end
      negative  = value[VALUE_BITS-1];
      // the most negative value negates to itself, which is its magnitude unsigned
      magnitude = negative ? (~value + 1'b1) : value;
      count = 0;
      do begin
         digits[count] = DIGIT_BITS'(magnitude % VALUE_BITS'(radix));
         magnitude     = magnitude / VALUE_BITS'(radix);
         count++;
      end while (magnitude != 0 && count < TEXT_DEPTH);
      if (negative) begin
         c.code = CHAR_MINUS;
         c.last = 1'b0;
         c.bad  = 1'b0;
         expected_chars.push_back(c);
      end
      for (int i = count - 1; i >= 0; i--) begin
         d = digits[i];
         if (d < DIGIT_TEN) begin
            c.code = CHAR_ZERO + CHAR_BITS'(d);
         end else begin
            c.code = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_BITS'(d - DIGIT_TEN);
         end
         c.last = (i == 0);
         c.bad  = 1'b0;
         expected_chars.push_back(c);
      end
   endfunction

   // offer one item from a falling edge, return at the falling edge after accept
   task automatic send_value(input logic [VALUE_BITS-1:0] value,
                             input logic [RADIX_BITS-1:0] radix,
                             input logic upper);
      int gap;
      // random idle burst ahead of the item
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, radix, value};
      req_tuser  <= upper;
      do @(posedge clock); while (!req_tready);
      predict_text(value, radix, upper);
      items_sent++;
      @(negedge clock);
   endtask

   // value of random length and sign, so texts of every size show up
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] v;
      v = VALUE_BITS'({$urandom, $urandom});
      v = v >> $urandom_range(0, VALUE_BITS - 1);
      if ($urandom_range(0, 1)) begin
         v = ~v + 1'b1;
      end
      return v;
   endfunction

   // mostly valid bases, some out of range on both sides
   function automatic logic [RADIX_BITS-1:0] random_radix();
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1)) begin
            return RADIX_BITS'($urandom_range(0, 1));
         end
         return RADIX_BITS'($urandom_range(37, 63));
      end
      return RADIX_BITS'($urandom_range(2, 36));
   endfunction

   // extremes of value and base, sign handling, both letter cases
   task automatic test_directed_extremes();
      send_value('0, 6'd10, 1'b0);                                // zero gives "0"
      send_value({1'b0, {62{1'b1}}}, 6'd2, 1'b0);                  // largest positive, 62 digits
      send_value({1'b1, 62'd0}, 6'd2, 1'b0);                       // minimum value, longest text
      send_value({1'b1, 62'd0}, 6'd36, 1'b1);                      // minimum value, widest base
      send_value({1'b0, {62{1'b1}}}, 6'd36, 1'b0);
      send_value({1'b0, {62{1'b1}}}, 6'd36, 1'b1);
      send_value('1, 6'd10, 1'b0);                                 // minus one
      send_value(63'd1, 6'd2, 1'b1);
      send_value(63'h0abc_def0_1234_5678, 6'd16, 1'b0);            // hex letters, lower
      send_value(63'h0abc_def0_1234_5678, 6'd16, 1'b1);            // hex letters, upper
      send_value(63'd35, 6'd36, 1'b0);                             // single letter z
      send_value(~63'd35 + 1'b1, 6'd36, 1'b1);                     // sign then Z
      send_value(63'd1295, 6'd36, 1'b1);                           // two top digits
      send_value(63'd12345, 6'd3, 1'b0);
      send_value(63'd1, 6'd10, 1'b0);
   endtask

   // bases just outside the valid range and the port extremes
   task automatic test_bad_radix();
      send_value(random_value(), 6'd0, 1'b0);
      send_value(random_value(), 6'd1, 1'b1);
      send_value(random_value(), 6'd37, 1'b0);
      send_value('1, 6'd63, 1'b1);
      send_value({1'b1, 62'd0}, 6'd1, 1'b0);
   endtask

   // random values, bases and cases with idling on both sides
   task automatic test_random_mix(input int count);
      repeat (count) begin
         send_value(random_value(), random_radix(), 1'(($urandom_range(0, 1))));
      end
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_backpressure();
      hold_request = LONG_HOLD_CYCLES;
      repeat (10) begin
         send_value(random_value(), RADIX_BITS'($urandom_range(2, 36)),
                    1'(($urandom_range(0, 1))));
      end
   endtask

   // back to back with no idling at all
   task automatic test_no_idle(input int count);
      idle_enable = 1'b0;
      test_random_mix(count);
   endtask

   // receiver: random stall bursts, and the long hold-off when asked
   initial begin
      int gap;
      int hold_len;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_len     = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (hold_len) @(negedge clock);
         end else if (idle_enable && !reset && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker: every accepted character against the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b bad %0b",
                                      rsp_tdata[6:0], rsp_tlast, rsp_tuser));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_tuser) begin
               bad_radix_seen++;
            end
            if (rsp_tdata[6:0] !== want.code) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_tdata[6:0], want.code));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("last_char %0b, expected %0b", rsp_tlast, want.last));
            end
            if (rsp_tuser !== want.bad) begin
               report_mismatch($sformatf("bad_radix %0b, expected %0b", rsp_tuser, want.bad));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still expected",
                  cycle_count, expected_chars.size());
         $display("signed_radix_to_ascii_top_test: done, errors");
         $finish;
      end
   end

   // main sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_bad_radix();
      test_random_mix(190);
      test_backpressure();
      test_no_idle(50);

      req_tvalid <= 1'b0;
      // wait for every expected character, then let the block settle
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d values (signs, zero, min/max, bases 0..63, both cases, long hold-off)",
               items_sent);
      $display("checked %0d characters, %0d of them flagged bad radix",
               chars_checked, bad_radix_seen);
      if (error_count == 0) begin
         $display("signed_radix_to_ascii_top_test: done, clean");
      end else begin
         $display("signed_radix_to_ascii_top_test: done, errors");
      end
      $finish;
   end

endmodule
